FILE: hdl/sd32_pkg.sv
// Shared constants and pipeline stage type for the signed divider.
package sd32_pkg;

    // Operand and result width
    localparam int DATA_WIDTH = 32;

    // Registered stages between an accepted start and its done strobe:
    // one operand stage, one stage per quotient bit, one result stage.
    localparam int LATENCY = DATA_WIDTH + 2;

    // Payload carried from stage to stage through the divide pipeline
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;     // partial remainder
        logic [DATA_WIDTH-1:0] nq;      // dividend bits shift out, quotient bits shift in
        logic [DATA_WIDTH-1:0] dsr;     // divisor magnitude
        logic                  neg_q;   // operand signs differ
        logic                  neg_r;   // dividend was negative
        logic                  dbz;     // divisor was zero
    } sd32_stage_t;

    // Two's complement negate
    function automatic logic [DATA_WIDTH-1:0] negate(input logic [DATA_WIDTH-1:0] v);
        negate = (~v) + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    endfunction

endpackage

FILE: hdl/sd32_prep.sv
// Operand stage: takes magnitudes and signs of the operands.
module sd32_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [sd32_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [sd32_pkg::DATA_WIDTH-1:0] divisor,
    output logic                           out_valid,
    output sd32_pkg::sd32_stage_t          out_stage
);
    import sd32_pkg::*;

    logic        valid_reg;
    sd32_stage_t stage_reg;
    sd32_stage_t stage_next;
    logic        sign_a;
    logic        sign_b;

    // Magnitudes and sign bookkeeping
    always_comb
    begin
        sign_a           = dividend[DATA_WIDTH-1];
        sign_b           = divisor[DATA_WIDTH-1];
        stage_next.rem   = '0;
        stage_next.nq    = sign_a ? negate(dividend) : dividend;
        stage_next.dsr   = sign_b ? negate(divisor) : divisor;
        stage_next.neg_q = sign_a ^ sign_b;
        stage_next.neg_r = sign_a;
        stage_next.dbz   = (divisor == '0);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, loaded only with a transaction
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

FILE: hdl/sd32_step.sv
// One restoring division step: shift in a dividend bit, trial subtract.
module sd32_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  sd32_pkg::sd32_stage_t in_stage,
    output logic                  out_valid,
    output sd32_pkg::sd32_stage_t out_stage
);
    import sd32_pkg::*;

    logic                  valid_reg;
    sd32_stage_t           stage_reg;
    sd32_stage_t           stage_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  qbit;

    // Trial subtract; the carry out of the shift always permits it
    always_comb
    begin
        shifted    = {in_stage.rem, in_stage.nq[DATA_WIDTH-1]};
        diff       = shifted - {1'b0, in_stage.dsr};
        qbit       = ~diff[DATA_WIDTH];
        stage_next = in_stage;
        stage_next.rem = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        stage_next.nq  = {in_stage.nq[DATA_WIDTH-2:0], qbit};
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

FILE: hdl/sd32_fix.sv
// Result stage: restores signs and applies the zero-divisor rule.
module sd32_fix (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  sd32_pkg::sd32_stage_t           in_stage,
    output logic                            done,
    output logic [sd32_pkg::DATA_WIDTH-1:0] quotient,
    output logic [sd32_pkg::DATA_WIDTH-1:0] remainder,
    output logic                            divide_by_zero
);
    import sd32_pkg::*;

    logic                  done_reg;
    logic [DATA_WIDTH-1:0] quot_reg;
    logic [DATA_WIDTH-1:0] quot_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic                  dbz_reg;

    // Sign fixup; with a zero divisor the remainder path returns the dividend
    always_comb
    begin
        if (in_stage.dbz)
        begin
            quot_next = '0;
        end
        else if (in_stage.neg_q)
        begin
            quot_next = negate(in_stage.nq);
        end
        else
        begin
            quot_next = in_stage.nq;
        end
        rem_next = in_stage.neg_r ? negate(in_stage.rem) : in_stage.rem;
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            dbz_reg  <= in_stage.dbz;
        end
    end

    assign done           = done_reg;
    assign quotient       = quot_reg;
    assign remainder      = rem_reg;
    assign divide_by_zero = dbz_reg;

endmodule

FILE: hdl/signed_divider_32_core.sv
// Top level of the pipelined signed 32-bit divider.
//
//  channel   handshake          payload
//  -------   ----------------   -------------------------------------------
//  input     start, busy        dividend[31:0], divisor[31:0]
//  result    done (strobe)      quotient[31:0], remainder[31:0], divide_by_zero
//
// One transaction may start every cycle; busy is always low.
// Each result passes through one operand stage, one restoring subtract
// stage per quotient bit and one sign-fixup stage.
// Results leave in start order, one per cycle at most, and are not held.
// rst_n clears only the valid bits; transactions in flight are dropped.
module signed_divider_32_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sd32_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [sd32_pkg::DATA_WIDTH-1:0] divisor,
    output logic                            done,
    output logic [sd32_pkg::DATA_WIDTH-1:0] quotient,
    output logic [sd32_pkg::DATA_WIDTH-1:0] remainder,
    output logic                            divide_by_zero
);
    import sd32_pkg::*;

    logic        accept;
    logic        stg_valid [0:DATA_WIDTH];
    sd32_stage_t stg       [0:DATA_WIDTH];

    // Never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Operand stage
    sd32_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (stg_valid[0]),
        .out_stage (stg[0])
    );

    // One division stage per quotient bit
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_step
        sd32_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_stage  (stg[i]),
            .out_valid (stg_valid[i+1]),
            .out_stage (stg[i+1])
        );
    end

    // Result stage
    sd32_fix u_fix (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (stg_valid[DATA_WIDTH]),
        .in_stage       (stg[DATA_WIDTH]),
        .done           (done),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

`ifndef SYNTHESIS
    // Every result traces back to an accepted start
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without matching start");

    // Zero divisor forces a zero quotient
    a_dbz_quot: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> quotient == '0)
        else $error("zero divisor gave nonzero quotient");

    // Final partial remainder magnitude is below the divisor magnitude
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[DATA_WIDTH] && !stg[DATA_WIDTH].dbz |->
            stg[DATA_WIDTH].rem < stg[DATA_WIDTH].dsr)
        else $error("remainder not reduced below divisor");

    // A nonzero remainder carries the sign of its dividend
    a_rem_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && remainder != '0 |->
            remainder[DATA_WIDTH-1] == $past(dividend[DATA_WIDTH-1], LATENCY))
        else $error("remainder sign differs from dividend");
`endif

endmodule
